// File: rtl/hti_pkg.sv
// Package for the heater thermostat interlock: command codes, queue entry type,
// arithmetic constants and the glass window check.
// No dependencies; imported by every module of the block.
package hti_pkg;

  localparam int VAL_W = 13;
  localparam int SP_W  = 8;
  localparam int CMD_W = 3;

  localparam logic [CMD_W-1:0] CMD_PHONE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DIAL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FRONT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BACK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_AMBIENT = 3'd4;

  localparam logic signed [VAL_W-1:0] DIAL_READ_ERR = -13'sd1;

  // floor(c / 10) = (c * 6554) >> 16 for c < 4096
  localparam int              CNT_W       = 12;
  localparam logic [12:0]     DIV10_RECIP = 13'd6554;
  localparam int              DIV10_SHIFT = 16;
  localparam int              Q_W         = 9;
  // floor(10*q*max / 1800) = floor(q*max / 180) = (x * 186414) >> 25 for x < 2^17
  localparam int              X_W          = Q_W + SP_W;
  localparam logic [17:0]     DIV180_RECIP = 18'd186414;
  localparam int              DIV180_SHIFT = 25;
  localparam int              NRAW_W       = 10;

  localparam logic [SP_W-1:0] DIAL_HYST     = 8'd2;
  localparam logic [SP_W-1:0] MAX_SP_RESET  = 8'd30;
  localparam logic signed [VAL_W-1:0] GLASS_LOW  = -13'sd50;
  localparam logic signed [VAL_W-1:0] GLASS_HIGH = 13'sd40;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PHONE,
    OP_DIAL,
    OP_FRONT,
    OP_BACK,
    OP_AMBIENT
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] val;
    logic [SP_W-1:0]         dial;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic glass_ok(input logic signed [VAL_W-1:0] t);
    return (t > GLASS_LOW) && (t < GLASS_HIGH);
  endfunction

endpackage

// File: rtl/hti_front.sv
// Front end: accepts sensor transactions, classifies them and scales dial samples
// in two registered stages before pushing into the queue. Depends on hti_pkg.
module hti_front import hti_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [SP_W-1:0]         max_setpoint,
  output logic                    push_valid,
  input  logic                    push_ready,
  output entry_t                  push_entry
);

  logic                    v1_r, v2_r;
  op_t                     op1_r, op2_r;
  logic signed [VAL_W-1:0] val1_r, val2_r;
  logic [Q_W-1:0]          q1_r;
  logic [X_W-1:0]          x2_r;

  op_t                     op_nxt;
  logic [CNT_W-1:0]        cnt;
  logic [24:0]             prod10;
  logic [X_W-1:0]          x_nxt;
  logic [34:0]             prod180;
  logic [NRAW_W-1:0]       nraw;
  logic                    en2;

  // Classify the command; a dial read error turns into a no-op.
  always_comb begin
    case (in_command)
      CMD_PHONE:   op_nxt = OP_PHONE;
      CMD_DIAL:    op_nxt = (in_value == DIAL_READ_ERR) ? OP_NONE : OP_DIAL;
      CMD_FRONT:   op_nxt = OP_FRONT;
      CMD_BACK:    op_nxt = OP_BACK;
      CMD_AMBIENT: op_nxt = OP_AMBIENT;
      default:     op_nxt = OP_NONE;
    endcase
  end

  // Negative counts clamp to zero, then divide by ten.
  assign cnt    = in_value[VAL_W-1] ? '0 : in_value[CNT_W-1:0];
  assign prod10 = 25'(cnt) * 25'(DIV10_RECIP);

  assign x_nxt = X_W'(q1_r) * X_W'(max_setpoint);

  assign prod180 = 35'(x2_r) * 35'(DIV180_RECIP);
  assign nraw    = prod180[DIV180_SHIFT +: NRAW_W];

  assign en2      = !v2_r || push_ready;
  assign in_ready = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (en2)      v2_r <= v1_r;
    end
    if (in_ready && in_valid) begin
      op1_r  <= op_nxt;
      val1_r <= in_value;
      q1_r   <= prod10[DIV10_SHIFT +: Q_W];
    end
    if (en2 && v1_r) begin
      op2_r  <= op1_r;
      val2_r <= val1_r;
      x2_r   <= x_nxt;
    end
  end

  assign push_valid     = v2_r;
  assign push_entry.op  = op2_r;
  assign push_entry.val = val2_r;
  // Clamp the scaled dial value to the maximum setpoint.
  assign push_entry.dial = (nraw >= NRAW_W'(max_setpoint)) ? max_setpoint : nraw[SP_W-1:0];

endmodule

// File: rtl/hti_queue.sv
// Short queue of classified transactions between front and back end.
// Depends on hti_pkg for the entry type and depth.
module hti_queue import hti_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry,
  output qstat_t stat
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                push, pop;

  localparam logic [QPTR_W-1:0] LAST = QPTR_W'(QDEPTH - 1);

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// File: rtl/hti_back.sv
// Back end: applies queued transactions to the thermostat state and drives the
// result register. Depends on hti_pkg.
module hti_back import hti_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  entry_t          pop_entry,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_heat_on,
  output logic [SP_W-1:0] out_setpoint,
  output logic            out_dial_changed
);

  logic [SP_W-1:0]         sp_r, sp_nxt;
  logic [SP_W-1:0]         dial_last_r, dial_last_nxt;
  logic signed [VAL_W-1:0] front_r, front_nxt;
  logic signed [VAL_W-1:0] back_r, back_nxt;
  logic signed [VAL_W-1:0] amb_r, amb_nxt;
  logic                    out_valid_r, heat_r, changed_r;
  logic [SP_W-1:0]         diff;
  logic                    changed_nxt, heat_nxt, take;

  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;

  assign diff = (pop_entry.dial >= dial_last_r) ? pop_entry.dial - dial_last_r
                                                : dial_last_r - pop_entry.dial;

  always_comb begin
    sp_nxt        = sp_r;
    dial_last_nxt = dial_last_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    amb_nxt       = amb_r;
    changed_nxt   = 1'b0;
    case (pop_entry.op)
      OP_PHONE:   sp_nxt = pop_entry.val[SP_W-1:0];
      OP_DIAL: begin
        if (diff >= DIAL_HYST) begin
          sp_nxt        = pop_entry.dial;
          dial_last_nxt = pop_entry.dial;
          changed_nxt   = 1'b1;
        end
      end
      OP_FRONT:   front_nxt = pop_entry.val;
      OP_BACK:    back_nxt  = pop_entry.val;
      OP_AMBIENT: amb_nxt   = pop_entry.val;
      default: ;
    endcase
    heat_nxt = glass_ok(front_nxt) && glass_ok(back_nxt) &&
               ($signed({{(VAL_W-SP_W){1'b0}}, sp_nxt}) > amb_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      dial_last_r <= '0;
      front_r     <= '0;
      back_r      <= '0;
      amb_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        sp_r        <= sp_nxt;
        dial_last_r <= dial_last_nxt;
        front_r     <= front_nxt;
        back_r      <= back_nxt;
        amb_r       <= amb_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      heat_r    <= heat_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_heat_on      = heat_r;
  assign out_setpoint     = sp_r;
  assign out_dial_changed = changed_r;

endmodule

// File: rtl/heater_thermostat_interlock.sv
// Top level of the heater thermostat interlock: config register, front end,
// queue and back end. Depends on hti_pkg, hti_front, hti_queue and hti_back.
//
// Usage:
//   in_*  : one sensor transaction per handshake (in_command tags the sensor,
//           in_value carries a temperature or a raw dial ADC count).
//   out_* : one result transaction per input: heater drive, current setpoint
//           and a flag for a dial sample that moved the setpoint.
//   cfg_* : writes max_setpoint (full-scale dial setpoint and clamp limit);
//           cfg_ready is always high. Write only while the block is idle.
// Path: an accepted transaction passes the two front stages, one queue slot and
//   the back end result register before it is shown on out_valid.
// Throughput: one transaction per cycle sustained while out_ready is high; the
//   three dial scaling multiplies sit in the two front stages and the queue write.
// Reset: rst_n is synchronous, active low. It empties the pipeline and queue,
//   zeroes setpoint, last dial value and all temperatures, and loads
//   max_setpoint with 30.
// Stall: while out_ready is low the result holds; the queue holds up to two
//   transactions and the front stages two more before in_ready drops.
module heater_thermostat_interlock import hti_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_heat_on,
  output logic [SP_W-1:0]         out_setpoint,
  output logic                    out_dial_changed,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SP_W-1:0]         cfg_max_setpoint
);

  logic [SP_W-1:0] max_sp_r;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  entry_t          push_entry, pop_entry;
  qstat_t          q_stat;

  // Config register: always ready, take the write on the handshake.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sp_r <= MAX_SP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_sp_r <= cfg_max_setpoint;
    end
  end

  // Classify and scale incoming transactions.
  hti_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_value     (in_value),
    .max_setpoint (max_sp_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  // Decouple front from back so either side can stall alone.
  hti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  // Update thermostat state and present the result.
  hti_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_entry        (pop_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heat_on      (out_heat_on),
    .out_setpoint     (out_setpoint),
    .out_dial_changed (out_dial_changed)
  );

  // Never write into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_ready) |-> !q_stat.full)
    else $error("queue push while full");

  // Never pop from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> !q_stat.empty)
    else $error("queue pop while empty");

  // A pop always lands in a free or draining result register.
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> (!out_valid || out_ready))
    else $error("result overwritten before delivery");

  // A pop always produces a result on the next cycle.
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> out_valid)
    else $error("popped transaction produced no result");

endmodule
